@@ rtl/pdp_pkg.sv @@
package pdp_pkg;

    // Build-time defaults for the top-level parameters
    localparam int PDP_MAX_READ_LENGTH = 1024;
    localparam int PDP_EMPIRICAL_DEPTH = 32;

    // APB register map
    localparam int PADDR_W = 5;
    localparam logic [2:0] REG_DECAY_FIVE   = 3'd0;
    localparam logic [2:0] REG_DECAY_THREE  = 3'd1;
    localparam logic [2:0] REG_PEAK_DAMAGE  = 3'd2;
    localparam logic [2:0] REG_BACKGROUND   = 3'd3;
    localparam logic [2:0] REG_EMP_FIVE_LEN = 3'd4;
    localparam logic [2:0] REG_EMP_THREE_LEN = 3'd5;

    // Request modes
    localparam logic [1:0] MODE_COMPUTE     = 2'd0;
    localparam logic [1:0] MODE_WRITE_FIVE  = 2'd1;
    localparam logic [1:0] MODE_WRITE_THREE = 2'd2;

    // Register stages inside the decay unit
    localparam int EXP_STAGES = 12;

    // Fixed-point constants
    localparam logic [24:0] LOG2E_Q24   = 25'h1715476;
    localparam logic [29:0] LN2_Q30     = 30'h2C5C85FE;
    // ceil(2^20 / 6): exact floor(v / 6) for v below 2^19
    localparam logic [17:0] DIV6_RECIP  = 18'd174763;

    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  position;
        logic [10:0] read_length;
        logic [4:0]  table_index;
        logic [15:0] table_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] ct_prob_five;
        logic [15:0] ga_prob_three;
        logic        out_of_range;
    } out_item_t;

    typedef struct packed {
        logic [15:0] decay_rate_five;
        logic [15:0] decay_rate_three;
        logic [15:0] peak_damage;
        logic [15:0] background_rate;
        logic [5:0]  empirical_five_length;
        logic [5:0]  empirical_three_length;
    } cfg_t;

    // 2^(-k/16) in Q.30, k = 0..15
    typedef logic [15:0][30:0] frac_rom_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = val;
        root = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Elaboration-time ROM build from chained square roots of 2^-1/2
    function automatic frac_rom_t build_frac_rom();
        logic [3:0][63:0] root;
        logic [63:0]      acc;
        frac_rom_t        rom;
        root[0] = isqrt64(64'd1 << 59);
        for (int j = 1; j < 4; j++) begin
            root[j] = isqrt64(root[j-1] << 30);
        end
        for (int k = 0; k < 16; k++) begin
            acc = 64'd1 << 30;
            for (int j = 0; j < 4; j++) begin
                if (((k >> (3 - j)) & 1) != 0) begin
                    acc = (acc * root[j] + (64'd1 << 29)) >> 30;
                end
            end
            rom[k] = acc[30:0];
        end
        return rom;
    endfunction

    localparam frac_rom_t FRAC_ROM = build_frac_rom();

endpackage

@@ rtl/positional_damage_profile.sv @@
// An accepted compute request passes the front stage, 12 decay stages and the
//   output register to m_valid; table writes and mode 3 give no result.
// Throughput: one request per cycle unless stalled, set by the fully pipelined
//   decay units; a two-entry output buffer keeps s_ready high while one
//   result waits. Reset: aresetn, synchronous, active low; clears cfg and
//   valid bits. Empirical tables are not cleared, hold unknowns until written.
module positional_damage_profile import pdp_pkg::*; #(
    parameter int MAX_READ_LENGTH = PDP_MAX_READ_LENGTH,
    parameter int EMPIRICAL_DEPTH = PDP_EMPIRICAL_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_item,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = (EMPIRICAL_DEPTH > 1) ? $clog2(EMPIRICAL_DEPTH) : 1;
    localparam logic [10:0] DEPTH_W11 = 11'(EMPIRICAL_DEPTH);

    // Sideband that rides alongside the decay units
    typedef struct packed {
        logic        oor;
        logic        use_five;
        logic        use_three;
        logic [15:0] tab_five;
        logic [15:0] tab_three;
    } side_t;

    cfg_t cfg;

    pdp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Flow control: the whole pipe moves on en. en drops only when both
    // output register and skid entry are full and the sink is stalled, so
    // nothing in flight is ever overwritten.
    // ------------------------------------------------------------------
    logic en;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    out_item_t out_reg;
    out_item_t out_next;
    out_item_t skid_reg;
    out_item_t skid_next;

    assign en      = !skid_valid_reg || m_ready;
    assign s_ready = en;

    logic accept;
    assign accept = s_valid && en;

    // ------------------------------------------------------------------
    // Front stage: range check, end distances and table hit decisions
    // ------------------------------------------------------------------
    logic [10:0] pos_w;
    logic [10:0] d3_w;
    logic        oor_w;
    logic        use_five_w;
    logic        use_three_w;
    logic [7:0]  idx_w8;
    logic        idx_ok;

    always_comb begin
        pos_w       = 11'(s_item.position);
        oor_w       = (pos_w >= s_item.read_length) ||
                      (32'(s_item.read_length) > MAX_READ_LENGTH);
        d3_w        = s_item.read_length - pos_w - 11'd1;
        // table length in use is capped at the table depth
        use_five_w  = (pos_w < 11'(cfg.empirical_five_length)) && (pos_w < DEPTH_W11);
        use_three_w = (d3_w < 11'(cfg.empirical_three_length)) && (d3_w < DEPTH_W11);
        idx_w8      = 8'(s_item.table_index);
        idx_ok      = 32'(s_item.table_index) < EMPIRICAL_DEPTH;
    end

    logic        f_oor_reg;
    logic        f_use_five_reg;
    logic        f_use_three_reg;
    logic [10:0] f_d5_reg;
    logic [10:0] f_d3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f_oor_reg       <= oor_w;
            f_use_five_reg  <= use_five_w;
            f_use_three_reg <= use_three_w;
            f_d5_reg        <= pos_w;
            f_d3_reg        <= d3_w;
        end
    end

    // Tables: writes land at the accept edge, reads register with the front
    // stage, so a compute request always sees every earlier write.
    logic [15:0] tab_five_rd;
    logic [15:0] tab_three_rd;

    pdp_table #(.DEPTH(EMPIRICAL_DEPTH)) u_table_five (
        .aclk    (aclk),
        .wr_en   (accept && (s_item.mode == MODE_WRITE_FIVE) && idx_ok),
        .wr_addr (idx_w8[IDX_W-1:0]),
        .wr_data (s_item.table_value),
        .rd_en   (en),
        .rd_addr (pos_w[IDX_W-1:0]),
        .rd_data (tab_five_rd)
    );

    pdp_table #(.DEPTH(EMPIRICAL_DEPTH)) u_table_three (
        .aclk    (aclk),
        .wr_en   (accept && (s_item.mode == MODE_WRITE_THREE) && idx_ok),
        .wr_addr (idx_w8[IDX_W-1:0]),
        .wr_data (s_item.table_value),
        .rd_en   (en),
        .rd_addr (d3_w[IDX_W-1:0]),
        .rd_data (tab_three_rd)
    );

    // ------------------------------------------------------------------
    // Decay units, one per read end
    // ------------------------------------------------------------------
    logic [15:0] prob_five;
    logic [15:0] prob_three;

    pdp_decay u_decay_five (
        .aclk       (aclk),
        .en         (en),
        .end_dist   (f_d5_reg),
        .lambda     (cfg.decay_rate_five),
        .peak       (cfg.peak_damage),
        .background (cfg.background_rate),
        .prob       (prob_five)
    );

    pdp_decay u_decay_three (
        .aclk       (aclk),
        .en         (en),
        .end_dist   (f_d3_reg),
        .lambda     (cfg.decay_rate_three),
        .peak       (cfg.peak_damage),
        .background (cfg.background_rate),
        .prob       (prob_three)
    );

    // ------------------------------------------------------------------
    // Valid bits and sideband line, aligned with the decay stages.
    // valid_reg[0] is the front stage; only compute requests make a result.
    // ------------------------------------------------------------------
    logic [EXP_STAGES:0] valid_reg;
    logic [EXP_STAGES:0] valid_next;
    side_t side_reg [EXP_STAGES];

    assign valid_next = en ? {valid_reg[EXP_STAGES-1:0],
                              s_valid && (s_item.mode == MODE_COMPUTE)}
                           : valid_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= '{oor:       f_oor_reg,
                             use_five:  f_use_five_reg,
                             use_three: f_use_three_reg,
                             tab_five:  tab_five_rd,
                             tab_three: tab_three_rd};
            for (int i = 1; i < EXP_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Final selection: out of range forces zeros, table hit beats the model
    side_t     side_last;
    out_item_t result;

    always_comb begin
        side_last = side_reg[EXP_STAGES-1];
        if (side_last.oor) begin
            result = '{ct_prob_five: 16'd0, ga_prob_three: 16'd0, out_of_range: 1'b1};
        end else begin
            result.ct_prob_five  = side_last.use_five  ? side_last.tab_five  : prob_five;
            result.ga_prob_three = side_last.use_three ? side_last.tab_three : prob_three;
            result.out_of_range  = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output register plus skid entry
    // ------------------------------------------------------------------
    logic push;
    logic pop;

    assign push = en && valid_reg[EXP_STAGES];
    assign pop  = out_valid_reg && m_ready;

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        priority if (skid_valid_reg) begin
            // full: en equals pop, so a push only comes with a pop
            if (pop) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = result;
                skid_valid_next = push;
            end
        end else if (!out_valid_reg || pop) begin
            out_next       = result;
            out_valid_next = push;
        end else begin
            if (push) begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

@@ rtl/pdp_cfg.sv @@
module pdp_cfg import pdp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_DECAY_FIVE:    cfg_next.decay_rate_five        = pwdata[15:0];
                REG_DECAY_THREE:   cfg_next.decay_rate_three       = pwdata[15:0];
                REG_PEAK_DAMAGE:   cfg_next.peak_damage            = pwdata[15:0];
                REG_BACKGROUND:    cfg_next.background_rate        = pwdata[15:0];
                REG_EMP_FIVE_LEN:  cfg_next.empirical_five_length  = pwdata[5:0];
                REG_EMP_THREE_LEN: cfg_next.empirical_three_length = pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DECAY_FIVE:    prdata = 32'(cfg_reg.decay_rate_five);
            REG_DECAY_THREE:   prdata = 32'(cfg_reg.decay_rate_three);
            REG_PEAK_DAMAGE:   prdata = 32'(cfg_reg.peak_damage);
            REG_BACKGROUND:    prdata = 32'(cfg_reg.background_rate);
            REG_EMP_FIVE_LEN:  prdata = 32'(cfg_reg.empirical_five_length);
            REG_EMP_THREE_LEN: prdata = 32'(cfg_reg.empirical_three_length);
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/pdp_table.sv @@
module pdp_table import pdp_pkg::*; #(
    parameter  int DEPTH  = PDP_EMPIRICAL_DEPTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [15:0]       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [15:0]       rd_data
);

    logic [15:0] mem_reg [DEPTH];
    logic [15:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

endmodule

@@ rtl/pdp_decay.sv @@
module pdp_decay import pdp_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [10:0] end_dist,
    input  logic [15:0] lambda,
    input  logic [15:0] peak,
    input  logic [15:0] background,
    output logic [15:0] prob
);

    // s0: x = lambda * end_dist
    logic [26:0] s0_x_reg;
    // s1: y = x * log2(e), split into integer n and fraction f
    logic        s1_big_reg;
    logic [4:0]  s1_n_reg;
    logic [29:0] s1_f_reg;
    // s2: t = r * ln2
    logic [25:0] s2_t_reg;
    logic [3:0]  s2_k_reg;
    logic [4:0]  s2_n_reg;
    logic        s2_big_reg;
    // s3: t^2
    logic [25:0] s3_t_reg;
    logic [21:0] s3_sq_reg;
    logic [3:0]  s3_k_reg;
    logic [4:0]  s3_n_reg;
    logic        s3_big_reg;
    // s4: t^3
    logic [25:0] s4_t_reg;
    logic [21:0] s4_sq_reg;
    logic [17:0] s4_cu_reg;
    logic [3:0]  s4_k_reg;
    logic [4:0]  s4_n_reg;
    logic        s4_big_reg;
    // s5: t^3 / 6
    logic [25:0] s5_t_reg;
    logic [21:0] s5_sq_reg;
    logic [15:0] s5_q_reg;
    logic [3:0]  s5_k_reg;
    logic [4:0]  s5_n_reg;
    logic        s5_big_reg;
    // s6: polynomial and ROM
    logic [30:0] s6_p_reg;
    logic [30:0] s6_rom_reg;
    logic [4:0]  s6_n_reg;
    logic        s6_big_reg;
    // s7: partial products of rom * p
    logic [45:0] s7_hi_reg;
    logic [46:0] s7_lo_reg;
    logic [4:0]  s7_n_reg;
    logic        s7_big_reg;
    // s8: rounded mantissa
    logic [30:0] s8_v_reg;
    logic [4:0]  s8_n_reg;
    logic        s8_big_reg;
    // s9..s11: scale, multiply by peak, add background
    logic [16:0] s9_e_reg;
    logic [32:0] s10_pm_reg;
    logic [15:0] s11_prob_reg;

    logic [26:0] x_prod;
    logic [51:0] y_sum;
    logic [55:0] t_sum;
    logic [51:0] sq_prod;
    logic [47:0] cu_prod;
    logic [35:0] q_prod;
    logic [31:0] p_sum;
    logic [45:0] hi_prod;
    logic [46:0] lo_prod;
    logic [61:0] v_sum;
    logic [31:0] round_sum;
    logic [31:0] shifted;
    logic [32:0] pm_prod;
    logic [33:0] pm_round;
    logic [18:0] prob_sum;

    always_comb begin
        x_prod    = 27'(lambda) * 27'(end_dist);
        y_sum     = 52'(s0_x_reg) * 52'(LOG2E_Q24) + 52'd128;
        t_sum     = 56'(s1_f_reg[25:0]) * 56'(LN2_Q30) + (56'd1 << 29);
        sq_prod   = 52'(s2_t_reg) * 52'(s2_t_reg);
        cu_prod   = 48'(s3_sq_reg) * 48'(s3_t_reg);
        q_prod    = 36'(s4_cu_reg) * 36'(DIV6_RECIP);
        p_sum     = (32'd1 << 30) - 32'(s5_t_reg) + 32'(s5_sq_reg >> 1) - 32'(s5_q_reg);
        hi_prod   = 46'(s6_rom_reg) * 46'(s6_p_reg[30:16]);
        lo_prod   = 47'(s6_rom_reg) * 47'(s6_p_reg[15:0]);
        v_sum     = {s7_hi_reg, 16'd0} + 62'(s7_lo_reg) + (62'd1 << 29);
        round_sum = {1'b0, s8_v_reg} + (32'd1 << (6'(s8_n_reg) + 6'd13));
        shifted   = round_sum >> (6'(s8_n_reg) + 6'd14);
        pm_prod   = 33'(peak) * 33'(s9_e_reg);
        pm_round  = 34'(s10_pm_reg) + 34'd32768;
        prob_sum  = 19'(pm_round[33:16]) + 19'(background);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_x_reg     <= x_prod;

            s1_big_reg   <= (y_sum[51:38] >= 14'd17);
            s1_n_reg     <= y_sum[42:38];
            s1_f_reg     <= y_sum[37:8];

            s2_t_reg     <= t_sum[55:30];
            s2_k_reg     <= s1_f_reg[29:26];
            s2_n_reg     <= s1_n_reg;
            s2_big_reg   <= s1_big_reg;

            s3_t_reg     <= s2_t_reg;
            s3_sq_reg    <= sq_prod[51:30];
            s3_k_reg     <= s2_k_reg;
            s3_n_reg     <= s2_n_reg;
            s3_big_reg   <= s2_big_reg;

            s4_t_reg     <= s3_t_reg;
            s4_sq_reg    <= s3_sq_reg;
            s4_cu_reg    <= cu_prod[47:30];
            s4_k_reg     <= s3_k_reg;
            s4_n_reg     <= s3_n_reg;
            s4_big_reg   <= s3_big_reg;

            s5_t_reg     <= s4_t_reg;
            s5_sq_reg    <= s4_sq_reg;
            s5_q_reg     <= q_prod[35:20];
            s5_k_reg     <= s4_k_reg;
            s5_n_reg     <= s4_n_reg;
            s5_big_reg   <= s4_big_reg;

            s6_p_reg     <= p_sum[30:0];
            s6_rom_reg   <= FRAC_ROM[s5_k_reg];
            s6_n_reg     <= s5_n_reg;
            s6_big_reg   <= s5_big_reg;

            s7_hi_reg    <= hi_prod;
            s7_lo_reg    <= lo_prod;
            s7_n_reg     <= s6_n_reg;
            s7_big_reg   <= s6_big_reg;

            s8_v_reg     <= v_sum[60:30];
            s8_n_reg     <= s7_n_reg;
            s8_big_reg   <= s7_big_reg;

            // n of 17 or more underflows to zero
            s9_e_reg     <= s8_big_reg ? 17'd0 : shifted[16:0];

            s10_pm_reg   <= pm_prod;

            s11_prob_reg <= (prob_sum > 19'd65535) ? 16'hFFFF : prob_sum[15:0];
        end
    end

    assign prob = s11_prob_reg;

endmodule

@@ sim/damage_check_pkg.sv @@
package damage_check_pkg;
    import pdp_pkg::*;

    localparam int READ_LEN_CAP = 1024;
    localparam int TABLE_DEPTH  = 32;

    // Fixed-point constants of the decay approximation
    localparam bit [63:0] LOG2E_FIX = 64'h1715476;   // log2(e), Q.24
    localparam bit [63:0] LN2_FIX   = 64'h2C5C85FE;  // ln(2), Q.30
    localparam bit [63:0] ONE_FIX   = 64'd1 << 30;

    class damage_scoreboard;
        bit [15:0] rate_five;
        bit [15:0] rate_three;
        bit [15:0] peak;
        bit [15:0] bg_rate;
        bit [5:0]  emp_len_five;
        bit [5:0]  emp_len_three;
        bit [15:0] emp_five [TABLE_DEPTH];
        bit [15:0] emp_three [TABLE_DEPTH];
        bit [63:0] pow_rom [16];
        out_item_t awaited [$];
        int        errs;

        function bit [63:0] int_sqrt(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] b;
            res = '0;
            b   = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // 2^(-k/16) in Q.30 from chained square roots of one half
        function new();
            bit [63:0] half_roots [4];
            bit [63:0] acc;
            half_roots[0] = int_sqrt(64'd1 << 59);
            for (int j = 1; j < 4; j++) begin
                half_roots[j] = int_sqrt(half_roots[j-1] << 30);
            end
            for (int k = 0; k < 16; k++) begin
                acc = ONE_FIX;
                for (int j = 0; j < 4; j++) begin
                    if (((k >> (3 - j)) & 1) != 0) begin
                        acc = (acc * half_roots[j] + (64'd1 << 29)) >> 30;
                    end
                end
                pow_rom[k] = acc;
            end
            errs = 0;
        endfunction

        function void report(string msg);
            $display("tb_top: mismatch: %s", msg);
            errs++;
        endfunction

        // exp(-rate * span), rate Q2.14, result Q0.16 in 0..65536
        function bit [16:0] decay_q16(bit [15:0] rate, bit [9:0] span);
            bit [63:0] x, y, n, f, r, t, t2, t3, p, v;
            x = 64'(rate) * 64'(span);
            y = (x * LOG2E_FIX + 64'd128) >> 8;
            n = y >> 30;
            if (n >= 17) begin
                return '0;
            end
            f  = y & (ONE_FIX - 1);
            r  = f & ((64'd1 << 26) - 1);
            t  = (r * LN2_FIX + (64'd1 << 29)) >> 30;
            t2 = (t * t) >> 30;
            t3 = (t2 * t) >> 30;
            p  = ONE_FIX - t + (t2 >> 1) - t3 / 6;
            v  = (pow_rom[f[29:26]] * p + (64'd1 << 29)) >> 30;
            v  = (v + (64'd1 << (13 + n))) >> (14 + n);
            return v[16:0];
        endfunction

        function bit [15:0] damage_prob(bit [15:0] rate, bit [9:0] span);
            bit [63:0] e;
            bit [63:0] s;
            e = 64'(decay_q16(rate, span));
            s = ((64'(peak) * e + 64'h8000) >> 16) + 64'(bg_rate);
            return (s > 64'hFFFF) ? 16'hFFFF : s[15:0];
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_DECAY_FIVE:    rate_five     = value[15:0];
                REG_DECAY_THREE:   rate_three    = value[15:0];
                REG_PEAK_DAMAGE:   peak          = value[15:0];
                REG_BACKGROUND:    bg_rate       = value[15:0];
                REG_EMP_FIVE_LEN:  emp_len_five  = value[5:0];
                REG_EMP_THREE_LEN: emp_len_three = value[5:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] register_value(logic [2:0] idx);
            case (idx)
                REG_DECAY_FIVE:    return {16'h0, rate_five};
                REG_DECAY_THREE:   return {16'h0, rate_three};
                REG_PEAK_DAMAGE:   return {16'h0, peak};
                REG_BACKGROUND:    return {16'h0, bg_rate};
                REG_EMP_FIVE_LEN:  return {26'h0, emp_len_five};
                REG_EMP_THREE_LEN: return {26'h0, emp_len_three};
                default:           return '0;
            endcase
        endfunction

        function void note_request(in_item_t req);
            out_item_t want;
            bit [9:0]  d3;
            int        lim5;
            int        lim3;
            case (req.mode)
                MODE_WRITE_FIVE: begin
                    if (int'(req.table_index) < TABLE_DEPTH) begin
                        emp_five[req.table_index] = req.table_value;
                    end
                end
                MODE_WRITE_THREE: begin
                    if (int'(req.table_index) < TABLE_DEPTH) begin
                        emp_three[req.table_index] = req.table_value;
                    end
                end
                MODE_COMPUTE: begin
                    if ({1'b0, req.position} >= req.read_length ||
                        int'(req.read_length) > READ_LEN_CAP) begin
                        want = '{16'h0, 16'h0, 1'b1};
                    end else begin
                        d3   = 10'(req.read_length - {1'b0, req.position} - 11'd1);
                        lim5 = (int'(emp_len_five) > TABLE_DEPTH) ? TABLE_DEPTH
                                                                  : int'(emp_len_five);
                        lim3 = (int'(emp_len_three) > TABLE_DEPTH) ? TABLE_DEPTH
                                                                   : int'(emp_len_three);
                        want.out_of_range  = 1'b0;
                        want.ct_prob_five  = (int'(req.position) < lim5)
                                           ? emp_five[req.position[4:0]]
                                           : damage_prob(rate_five, req.position);
                        want.ga_prob_three = (int'(d3) < lim3)
                                           ? emp_three[d3[4:0]]
                                           : damage_prob(rate_three, d3);
                    end
                    awaited.push_back(want);
                end
                default: ;
            endcase
        endfunction

        function void check_profile(out_item_t got);
            out_item_t want;
            if (awaited.size() == 0) begin
                report($sformatf("result %h with nothing awaited", got));
                return;
            end
            want = awaited.pop_front();
            if (got.ct_prob_five !== want.ct_prob_five) begin
                report($sformatf("ct_prob_five %h, want %h",
                                 got.ct_prob_five, want.ct_prob_five));
            end
            if (got.ga_prob_three !== want.ga_prob_three) begin
                report($sformatf("ga_prob_three %h, want %h",
                                 got.ga_prob_three, want.ga_prob_three));
            end
            if (got.out_of_range !== want.out_of_range) begin
                report($sformatf("out_of_range %b, want %b",
                                 got.out_of_range, want.out_of_range));
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

endpackage

@@ sim/tb_top.sv @@
module tb_top;
    import pdp_pkg::*;
    import damage_check_pkg::*;

    // Mode 3 has no meaning; the block must swallow it without a result
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Cycles without any handshake before the run is declared hung
    localparam int IDLE_LIMIT = 2000;
    // Quiet cycles after the last result before a register write:
    // covers the pipeline for table writes that give no result
    localparam int SETTLE_CYCLES = 20;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_item;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    damage_scoreboard   sb;

    // Idle pacing: each side runs stretches of random waits and stretches of none
    int tx_left = 0;
    bit tx_calm = 1'b0;
    int rx_left = 0;
    bit rx_calm = 1'b0;
    int rx_hold = 0;

    positional_damage_profile #(
        .MAX_READ_LENGTH(READ_LEN_CAP),
        .EMPIRICAL_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_wait(inout int left, inout bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            left = int'($urandom_range(8, 60));
        end
        left--;
        return calm ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic in_item_t compute_req(int pos, int len);
        in_item_t req;
        req.mode        = MODE_COMPUTE;
        req.position    = 10'(pos);
        req.read_length = 11'(len);
        req.table_index = 5'($urandom);
        req.table_value = 16'($urandom);
        return req;
    endfunction

    function automatic in_item_t table_req(logic [1:0] mode, int idx, int val);
        in_item_t req;
        req.mode        = mode;
        req.position    = 10'($urandom);
        req.read_length = 11'($urandom);
        req.table_index = 5'(idx);
        req.table_value = 16'(val);
        return req;
    endfunction

    // Random request: mostly well-formed computes biased towards both read
    // ends (where the decay is not yet flat), plus table writes, mode 3 and
    // out-of-range positions and over-long reads.
    function automatic in_item_t draw_request();
        int roll;
        int len;
        int pos;
        int reach;
        roll = int'($urandom_range(0, 99));
        if (roll < 10) begin
            return table_req((roll < 5) ? MODE_WRITE_FIVE : MODE_WRITE_THREE,
                             int'($urandom_range(0, 31)), int'($urandom_range(0, 65535)));
        end
        if (roll < 13) begin
            return table_req(MODE_UNUSED, int'($urandom_range(0, 31)),
                             int'($urandom_range(0, 65535)));
        end
        if (roll < 17) begin
            // position at or past the end of the read
            len = int'($urandom_range(0, 1023));
            pos = int'($urandom_range(len, 1023));
        end else if (roll < 22) begin
            // read longer than the block supports
            len = int'($urandom_range(1025, 2047));
            pos = int'($urandom_range(0, 1023));
        end else begin
            case ($urandom_range(0, 3))
                0:       len = int'($urandom_range(1, 16));
                1:       len = int'($urandom_range(1, 128));
                2:       len = int'($urandom_range(1, 1024));
                default: len = READ_LEN_CAP;
            endcase
            reach = (len < 40) ? len - 1 : 39;
            case ($urandom_range(0, 2))
                0:       pos = int'($urandom_range(0, reach));
                1:       pos = len - 1 - int'($urandom_range(0, reach));
                default: pos = int'($urandom_range(0, len - 1));
            endcase
        end
        return compute_req(pos, len);
    endfunction

    // Present one request after a random gap and hold it until taken
    task automatic send_request(input in_item_t req);
        int gap;
        gap = pick_wait(tx_left, tx_calm);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req);
    endtask

    // Drop valid, wait for every awaited result, then a quiet tail
    task automatic drain_results(input int tail);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    // APB write, then a read back of the same register
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_register(idx, value);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== sb.register_value(idx)) begin
            sb.report($sformatf("register %0d reads %h, want %h",
                                idx, prdata, sb.register_value(idx)));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers change only with the pipeline empty
    task automatic apply_setting(input logic [31:0] rate5, input logic [31:0] rate3,
                                 input logic [31:0] pk, input logic [31:0] bg,
                                 input logic [31:0] len5, input logic [31:0] len3);
        drain_results(SETTLE_CYCLES);
        write_register(REG_DECAY_FIVE, rate5);
        write_register(REG_DECAY_THREE, rate3);
        write_register(REG_PEAK_DAMAGE, pk);
        write_register(REG_BACKGROUND, bg);
        write_register(REG_EMP_FIVE_LEN, len5);
        write_register(REG_EMP_THREE_LEN, len3);
    endtask

    // Result side: sample at the rising edge, then a random stall, possibly none
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_profile(m_item);
            rx_hold = pick_wait(rx_left, rx_calm);
        end
    end

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Hang detector: any handshake on any port resets the count
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        logic [31:0] rate5, rate3, pk, bg, len5, len3;
        sb = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Fill both tables so no table read ever hits an unwritten entry
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_request(table_req(MODE_WRITE_FIVE, i, int'($urandom_range(0, 65535))));
            send_request(table_req(MODE_WRITE_THREE, i, int'($urandom_range(0, 65535))));
        end
        // Reset settings: everything zero, so every probability is zero
        send_request(compute_req(3, 10));
        send_request(compute_req(0, 1));

        apply_setting(32'h4000, 32'h2000, 32'h8000, 32'h0100, 32'd8, 32'd4);
        // Directed: single-base read, full-length read ends, the out-of-range
        // boundaries, table/formula crossover at both ends, a write followed
        // at once by a read of that entry, and mode 3 with every bit set.
        send_request(compute_req(0, 1));
        send_request(compute_req(0, 1024));
        send_request(compute_req(1023, 1024));
        send_request(compute_req(1023, 1023));
        send_request(compute_req(0, 0));
        send_request(compute_req(5, 2047));
        send_request(compute_req(10, 1025));
        send_request(compute_req(7, 20));
        send_request(compute_req(8, 20));
        send_request(compute_req(16, 20));
        send_request(compute_req(15, 20));
        send_request(table_req(MODE_WRITE_FIVE, 31, 16'hFFFF));
        send_request(table_req(MODE_WRITE_THREE, 0, 16'h0000));
        send_request(table_req(MODE_WRITE_FIVE, 0, 16'hFFFF));
        send_request(compute_req(0, 1));
        send_request('{MODE_UNUSED, 10'h3FF, 11'h7FF, 5'h1F, 16'hFFFF});
        send_request(compute_req(511, 1024));
        send_request(compute_req(0, 2));

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin  // no decay, saturating sum, tables off
                    rate5 = 32'h0; rate3 = 32'h0; pk = 32'hFFFF; bg = 32'hFFFF;
                    len5 = 32'd0;  len3 = 32'd0;
                end
                1: begin  // steepest decay, full tables
                    rate5 = 32'hFFFF; rate3 = 32'hFFFF; pk = 32'hFFFF; bg = 32'h0;
                    len5 = 32'd32;    len3 = 32'd32;
                end
                2: begin  // slowest decay, lengths beyond the table depth
                    rate5 = 32'h1; rate3 = 32'h1; pk = 32'h1; bg = 32'hFFFF;
                    len5 = 32'd63; len3 = 32'd40;
                end
                3: begin
                    rate5 = 32'h4000; rate3 = 32'h0800; pk = 32'h7FFF; bg = 32'h0010;
                    len5 = 32'd1;     len3 = 32'd31;
                end
                default: begin
                    rate5 = 32'($urandom_range(0, 65535) >> $urandom_range(0, 15));
                    rate3 = 32'($urandom_range(0, 65535) >> $urandom_range(0, 15));
                    pk    = 32'($urandom_range(0, 65535));
                    bg    = 32'($urandom_range(0, 65535) >> $urandom_range(0, 16));
                    len5  = 32'($urandom_range(0, 40));
                    len3  = 32'($urandom_range(0, 40));
                end
            endcase
            apply_setting(rate5, rate3, pk, bg, len5, len3);
            for (int i = 0; i < 200; i++) begin
                // once, let the pipeline run completely dry mid-phase
                if (ph == 2 && i == 100) begin
                    drain_results(0);
                end
                send_request(draw_request());
            end
        end

        drain_results(30);
        if (sb.errs == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
